// ===== design/fembc_pkg.sv =====
package fembc_pkg;

  localparam int MAX_NODES_DEF = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int IDX_W    = 16;
  localparam int CRD_W    = 32;
  localparam int VAL_W    = 48;
  localparam int NCNT_W   = 13;
  localparam int PROD_W   = 66;
  localparam int ROOT_W   = 33;
  localparam int DIV_W    = 72;
  localparam int DIV_STEP = 8;

  localparam logic [NCNT_W-1:0] NCNT_RST = 13'd4096;

  localparam logic [1:0] ACT_FACE  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_DIRICHLET = 2'd1;
  localparam logic [1:0] KIND_NEUMANN   = 2'd2;
  localparam logic [1:0] KIND_ROBIN     = 2'd3;

  localparam logic RES_TRIPLET = 1'b0;
  localparam logic RES_LOAD    = 1'b1;

  localparam logic [VAL_W-1:0] POS48 = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG48 = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [DIV_W-1:0] LIM_POS = {{(DIV_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic [DIV_W-1:0] LIM_NEG = LIM_POS + DIV_W'(1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_RD_LOAD, ST_RD_OUT, ST_MUL_X, ST_MUL_Y,
    ST_SQ_GO, ST_SQRT, ST_SC_MUL, ST_SC_ADD, ST_SC_DIV, ST_SC_FIN, ST_EMIT,
    ST_LD_RD, ST_LD_WR
  } fembc_state_t;

  typedef enum logic [1:0] {PASS_DIAG, PASS_OFF, PASS_HALF} fembc_pass_t;

  // magnitude with sign applied, saturated to signed 48 bits
  function automatic logic [VAL_W-1:0] sat_mag(input logic neg, input logic [DIV_W-1:0] q);
    logic [VAL_W-1:0] res;
    if (neg) begin
      res = (q > LIM_NEG) ? NEG48 : VAL_W'(~q[VAL_W-1:0] + VAL_W'(1));
    end else begin
      res = (q > LIM_POS) ? POS48 : q[VAL_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    logic [VAL_W-1:0] res;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      res = s[VAL_W] ? NEG48 : POS48;
    end else begin
      res = s[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/fembc_if.sv =====
interface fembc_in_if import fembc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [1:0]              face_kind;
  logic [IDX_W-1:0]        node_a;
  logic [IDX_W-1:0]        node_b;
  logic signed [CRD_W-1:0] ax;
  logic signed [CRD_W-1:0] ay;
  logic signed [CRD_W-1:0] bx;
  logic signed [CRD_W-1:0] by_coord;
  logic signed [CRD_W-1:0] flux_coef;
  logic signed [CRD_W-1:0] robin_k;
  logic signed [CRD_W-1:0] robin_g;
  logic signed [VAL_W-1:0] load_data;

  modport source (output valid, action, face_kind, node_a, node_b, ax, ay, bx, by_coord,
                  flux_coef, robin_k, robin_g, load_data, input ready);
  modport sink (input valid, action, face_kind, node_a, node_b, ax, ay, bx, by_coord,
                flux_coef, robin_k, robin_g, load_data, output ready);
endinterface

interface fembc_out_if import fembc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] value;
  logic                    is_last;

  modport source (output valid, result_kind, row_index, col_index, value, is_last,
                  input ready);
  modport sink (input valid, result_kind, row_index, col_index, value, is_last,
                output ready);
endinterface

interface fembc_cfg_if import fembc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NCNT_W-1:0] node_count;

  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

// ===== design/fembc_mul.sv =====
module fembc_mul import fembc_pkg::*; (
  input  logic              clk,
  input  logic [ROOT_W-1:0] a,
  input  logic [ROOT_W-1:0] b,
  output logic [PROD_W-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

// ===== design/fembc_sqrt.sv =====
module fembc_sqrt import fembc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  localparam int REM_W = ROOT_W + 3;

  logic [PROD_W-1:0] rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [5:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // one result bit per cycle, digit-by-digit restoring form
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[PROD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        rad_r  <= {rad_r[PROD_W-3:0], 2'b00};
        rem_r  <= ge ? REM_W'(rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], ge};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(ROOT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ===== design/fembc_div3.sv =====
module fembc_div3 import fembc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  output logic             done,
  output logic [DIV_W-1:0] quot
);
  localparam int ITER = DIV_W / DIV_STEP;

  logic [DIV_W-1:0] n_r;
  logic [1:0]       r_r;
  logic [3:0]       cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DIV_W-1:0] n_nxt;
  logic [1:0]       r_nxt;

  // several quotient bits per cycle; the remainder is only two bits wide
  always_comb begin
    logic [2:0] t;
    n_nxt = n_r;
    r_nxt = r_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      t     = {r_nxt, n_nxt[DIV_W-1]};
      n_nxt = {n_nxt[DIV_W-2:0], 1'b0};
      if (t >= 3'd3) begin
        n_nxt[0] = 1'b1;
        r_nxt    = 2'(t - 3'd3);
      end else begin
        r_nxt = t[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r   <= num;
        r_r   <= 2'd0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        n_r   <= n_nxt;
        r_r   <= r_nxt;
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(ITER - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = n_r;
endmodule

// ===== design/fembc_lmem.sv =====
module fembc_lmem import fembc_pkg::*; #(
  parameter int DEPTH = MAX_NODES_DEF,
  parameter int AW    = $clog2(MAX_NODES_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata_r
);
  logic [VAL_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end
endmodule

// ===== design/fem_edge_natural_bc_assembly.sv =====
// boundary edge assembly for linear 2-d elements, natural conditions
// in_ch beat: one action. process face (neumann/robin) computes the edge length
//   with an iterative square root, scales coefficients and updates the load store;
//   write load entry stores load_data; read load entry returns one beat on out_ch
// out_ch beat: a robin face gives four stiffness triplets, a read gives one load
//   beat; is_last marks the final beat of the action
// cfg_ch beat: writes node_count, always ready; write only while idle
// in_ch.ready is high only in the idle state; one action is worked at a time
// reads and robin faces also wait for the receiver; neumann and robin faces wait
//   on the iterative square root, and robin faces also on the divide-by-three
//   unit (run twice per robin face); these units work around one shared
//   multiplier
// the load store is one memory, one write and one registered read port;
//   load updates are read-modify-write with 48-bit saturation
// reset: node_count returns to 4096 and a clearing pass writes zero to all
//   MAX_NODES entries, one per cycle, before in_ch.ready first rises
// receiver stall: a result beat is held in the output register until taken,
//   and the sequencer waits
module fem_edge_natural_bc_assembly import fembc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  fembc_in_if.sink    in_ch,
  fembc_out_if.source out_ch,
  fembc_cfg_if.sink   cfg_ch
);
  localparam int AW = $clog2(MAX_NODES);
  localparam logic [IDX_W:0] MAXN = (IDX_W+1)'(MAX_NODES);
  // rounding offsets of half the divisor (den << FRAC_BITS) / 2
  localparam logic [PROD_W:0] RND_DIAG = (PROD_W+1)'(3) << (FRAC_BITS - 1);
  localparam logic [PROD_W:0] RND_OFF  = (PROD_W+1)'(3) << FRAC_BITS;
  localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << FRAC_BITS;

  fembc_state_t state_r, state_nxt;
  fembc_pass_t  pass_r;

  logic [NCNT_W-1:0]       ncnt_r;
  logic [AW-1:0]           clr_r;
  logic [1:0]              act_r, kind_r;
  logic [IDX_W-1:0]        na_r, nb_r;
  logic signed [CRD_W-1:0] ax_r, ay_r, bx_r, by_r, flux_r, k_r, g_r;
  logic [VAL_W-1:0]        ld_r;
  logic [ROOT_W-1:0]       ux_r, uy_r;
  logic [PROD_W-1:0]       x2_r;
  logic [DIV_W-1:0]        q_r;
  logic [VAL_W-1:0]        diag_r, off_r, half_r;
  logic [1:0]              tri_r;
  logic                    sel_b_r;

  logic                    out_valid_r, out_kind_r, out_last_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic [VAL_W-1:0]        out_val_r;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [VAL_W-1:0]        mem_wdata, mem_rdata;
  logic [ROOT_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic                    sq_start, sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic                    dv_start, dv_done;
  logic [DIV_W-1:0]        dv_quot, sc_num;
  logic [PROD_W:0]         sc_sum;

  logic                    a_in_mem, b_in_mem, a_ok, b_ok;
  logic signed [CRD_W:0]   dx, dy;
  logic signed [CRD_W-1:0] coef;
  logic                    coef_neg;
  logic [ROOT_W-1:0]       coef_abs;
  logic [VAL_W-1:0]        fin_val;
  logic [IDX_W-1:0]        ld_node;
  logic                    out_take;

  assign a_in_mem = ({1'b0, na_r} < MAXN);
  assign b_in_mem = ({1'b0, nb_r} < MAXN);
  assign a_ok     = a_in_mem && (na_r < {{(IDX_W-NCNT_W){1'b0}}, ncnt_r});
  assign b_ok     = b_in_mem && (nb_r < {{(IDX_W-NCNT_W){1'b0}}, ncnt_r});

  assign dx = {bx_r[CRD_W-1], bx_r} - {ax_r[CRD_W-1], ax_r};
  assign dy = {by_r[CRD_W-1], by_r} - {ay_r[CRD_W-1], ay_r};

  // coefficient of the current scaling pass
  always_comb begin
    if (pass_r == PASS_HALF) begin
      coef = (kind_r == KIND_NEUMANN) ? flux_r : g_r;
    end else begin
      coef = k_r;
    end
    coef_neg = coef[CRD_W-1];
    coef_abs = coef_neg ? ROOT_W'(-{coef[CRD_W-1], coef}) : {1'b0, coef};
  end

  // |c|*L plus half the divisor, then the power-of-two part of the divide
  always_comb begin
    unique case (pass_r)
      PASS_DIAG: begin
        sc_sum = {1'b0, mul_p} + RND_DIAG;
        sc_num = DIV_W'(sc_sum >> FRAC_BITS);
      end
      PASS_OFF: begin
        sc_sum = {1'b0, mul_p} + RND_OFF;
        sc_num = DIV_W'(sc_sum >> (FRAC_BITS + 1));
      end
      default: begin
        sc_sum = {1'b0, mul_p} + RND_HALF;
        sc_num = DIV_W'(sc_sum >> (FRAC_BITS + 1));
      end
    endcase
  end

  assign fin_val  = sat_mag(coef_neg, q_r);
  assign ld_node  = sel_b_r ? nb_r : na_r;
  assign out_take = out_valid_r && out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (clr_r == AW'(MAX_NODES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        priority if (act_r == ACT_READ) begin
          state_nxt = ST_RD_LOAD;
        end else if (act_r == ACT_FACE && (kind_r == KIND_NEUMANN || kind_r == KIND_ROBIN)
                     && a_ok && b_ok) begin
          state_nxt = ST_MUL_X;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_LOAD: state_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (out_take) state_nxt = ST_IDLE;
      ST_MUL_X:   state_nxt = ST_MUL_Y;
      ST_MUL_Y:   state_nxt = ST_SQ_GO;
      ST_SQ_GO:   state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sq_done) state_nxt = (sq_root == '0) ? ST_IDLE : ST_SC_MUL;
      end
      ST_SC_MUL:  state_nxt = ST_SC_ADD;
      ST_SC_ADD:  state_nxt = (pass_r == PASS_HALF) ? ST_SC_FIN : ST_SC_DIV;
      ST_SC_DIV:  if (dv_done) state_nxt = ST_SC_FIN;
      ST_SC_FIN: begin
        unique case (pass_r)
          PASS_DIAG: state_nxt = ST_SC_MUL;
          PASS_OFF:  state_nxt = ST_EMIT;
          default:   state_nxt = ST_LD_RD;
        endcase
      end
      ST_EMIT:    if (out_take && tri_r == 2'd3) state_nxt = ST_SC_MUL;
      ST_LD_RD:   state_nxt = ST_LD_WR;
      ST_LD_WR:   state_nxt = sel_b_r ? ST_IDLE : ST_LD_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // unit and memory controls
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = na_r[AW-1:0];
    mem_wdata   = ld_r;
    mem_raddr   = na_r[AW-1:0];
    mul_a       = ux_r;
    mul_b       = ux_r;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_DECODE: mem_we = (act_r == ACT_WRITE) && a_in_mem;
      ST_MUL_Y: begin
        mul_a = uy_r;
        mul_b = uy_r;
      end
      ST_SQ_GO:  sq_start = 1'b1;
      ST_SC_MUL: begin
        mul_a = coef_abs;
        mul_b = sq_root;
      end
      ST_SC_ADD: dv_start = (pass_r != PASS_HALF);
      ST_LD_RD:  mem_raddr = ld_node[AW-1:0];
      ST_LD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ld_node[AW-1:0];
        mem_wdata = sat_add(mem_rdata, half_r);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ncnt_r      <= NCNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (cfg_ch.valid) ncnt_r <= cfg_ch.node_count;
      if (out_take) begin
        out_valid_r <= 1'b0;
      end else if (state_r == ST_RD_LOAD || (state_r == ST_EMIT && !out_valid_r)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        act_r  <= in_ch.action;
        kind_r <= in_ch.face_kind;
        na_r   <= in_ch.node_a;
        nb_r   <= in_ch.node_b;
        ax_r   <= in_ch.ax;
        ay_r   <= in_ch.ay;
        bx_r   <= in_ch.bx;
        by_r   <= in_ch.by_coord;
        flux_r <= in_ch.flux_coef;
        k_r    <= in_ch.robin_k;
        g_r    <= in_ch.robin_g;
        ld_r   <= in_ch.load_data;
      end
      ST_DECODE: begin
        ux_r    <= dx[CRD_W] ? ROOT_W'(-dx) : ROOT_W'(dx);
        uy_r    <= dy[CRD_W] ? ROOT_W'(-dy) : ROOT_W'(dy);
        pass_r  <= (kind_r == KIND_ROBIN) ? PASS_DIAG : PASS_HALF;
        sel_b_r <= 1'b0;
      end
      ST_RD_LOAD: begin
        out_kind_r <= RES_LOAD;
        out_row_r  <= na_r;
        out_col_r  <= '0;
        out_val_r  <= a_in_mem ? mem_rdata : '0;
        out_last_r <= 1'b1;
      end
      ST_MUL_Y:  x2_r <= mul_p;
      ST_SC_ADD: q_r <= sc_num;
      ST_SC_DIV: if (dv_done) q_r <= dv_quot;
      ST_SC_FIN: begin
        unique case (pass_r)
          PASS_DIAG: begin
            diag_r <= fin_val;
            pass_r <= PASS_OFF;
          end
          PASS_OFF: begin
            off_r <= fin_val;
            tri_r <= 2'd0;
          end
          default: half_r <= fin_val;
        endcase
      end
      ST_EMIT: begin
        // triplet order: (a,a) diag, (a,b) off, (b,a) off, (b,b) diag
        if (!out_valid_r) begin
          out_kind_r <= RES_TRIPLET;
          out_row_r  <= tri_r[1] ? nb_r : na_r;
          out_col_r  <= tri_r[0] ? nb_r : na_r;
          out_val_r  <= (tri_r[0] == tri_r[1]) ? diag_r : off_r;
          out_last_r <= (tri_r == 2'd3);
        end else if (out_ch.ready) begin
          tri_r <= tri_r + 2'd1;
          if (tri_r == 2'd3) pass_r <= PASS_HALF;
        end
      end
      ST_LD_WR: sel_b_r <= 1'b1;
      default: ;
    endcase
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.row_index   = out_row_r;
  assign out_ch.col_index   = out_col_r;
  assign out_ch.value       = out_val_r;
  assign out_ch.is_last     = out_last_r;

  fembc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  fembc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (x2_r + mul_p),
    .done  (sq_done),
    .root  (sq_root)
  );

  // the dividend is taken straight from the scaling sum as the unit starts
  fembc_div3 u_div3 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (sc_num),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  fembc_lmem #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_lmem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

endmodule

// ===== test/fembc_tb_if.sv =====
`timescale 1ns / 1ps

// the block's own interfaces carry the channels; this file only keeps
// the beat records the testbench queues for the driver and the monitor
package fembc_tb_pkg;
  import fembc_pkg::*;

  typedef struct {
    logic [1:0]        action;
    logic [1:0]        face_kind;
    logic [IDX_W-1:0]  node_a;
    logic [IDX_W-1:0]  node_b;
    logic [CRD_W-1:0]  ax, ay, bx, by_coord;
    logic [CRD_W-1:0]  flux_coef, robin_k, robin_g;
    logic [VAL_W-1:0]  load_data;
  } face_beat_t;

  typedef struct {
    logic              result_kind;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [VAL_W-1:0]  value;
    logic              is_last;
  } result_beat_t;
endpackage

// ===== test/tb_fem_edge_natural_bc_assembly.sv =====
`timescale 1ns / 1ps

module tb_fem_edge_natural_bc_assembly;
  import fembc_pkg::*;
  import fembc_tb_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fembc_in_if  in_ch ();
  fembc_out_if out_ch ();
  fembc_cfg_if cfg_ch ();

  fem_edge_natural_bc_assembly dut (
    .clk(clk), .rst_n(rst_n),
    .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block state
  logic signed [VAL_W-1:0] load_shadow [NODES];
  logic [NCNT_W-1:0] node_limit;

  face_beat_t   pending_beats[$];
  result_beat_t expected_results[$];

  int mismatches = 0;
  int drv_wait = 0;
  int rcv_wait = 0;
  int long_hold = 0;
  int idle_cycles = 0;

  function automatic void queue_beat(input face_beat_t f);
    pending_beats = {pending_beats, f};
  endfunction

  function automatic void add_expected(input result_beat_t r);
    expected_results = {expected_results, r};
  endfunction

  // ---------------- predictor ----------------

  function automatic logic signed [VAL_W-1:0] sat_sum48(logic signed [VAL_W-1:0] a,
                                                       logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s > 49'sh0_7FFF_FFFF_FFFF) return {1'b0, {(VAL_W-1){1'b1}}};
    if (s < -49'sh0_8000_0000_0000) return {1'b1, {(VAL_W-1){1'b0}}};
    return s[VAL_W-1:0];
  endfunction

  // floor(sqrt(dx^2 + dy^2)) by bitwise search on exact 67-bit squares
  function automatic logic [32:0] edge_len(logic signed [CRD_W-1:0] ax,
                                           logic signed [CRD_W-1:0] ay,
                                           logic signed [CRD_W-1:0] bx,
                                           logic signed [CRD_W-1:0] by_c);
    logic signed [33:0] dx, dy;
    logic [66:0] sum;
    logic [66:0] trial_sq;
    logic [32:0] root, trial;
    dx = 34'(bx) - 34'(ax);
    dy = 34'(by_c) - 34'(ay);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sum = 67'(dx) * 67'(dx) + 67'(dy) * 67'(dy);
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (33'd1 << b);
      trial_sq = 67'(trial) * 67'(trial);
      if (trial_sq <= sum) root = trial;
    end
    return root;
  endfunction

  // coefficient * length / (den << frac), round half away, saturate to 48 bits
  function automatic logic signed [VAL_W-1:0] scale_term(logic signed [CRD_W-1:0] c,
                                                         logic [32:0] len, int den);
    logic [71:0] mag, d, q, r;
    logic neg;
    neg = c < 0;
    mag = neg ? 72'(-(64'(c))) : 72'(c);
    mag = mag * 72'(len);
    d = 72'(den) << FB;
    q = mag / d;
    r = mag % d;
    if (r >= d - r) q = q + 1;
    if (neg) begin
      if (q > 72'h8000_0000_0000) return {1'b1, {(VAL_W-1){1'b0}}};
      return -(q[VAL_W-1:0]);
    end
    if (q > 72'h7FFF_FFFF_FFFF) return {1'b0, {(VAL_W-1){1'b1}}};
    return q[VAL_W-1:0];
  endfunction

  function automatic result_beat_t make_result(logic kind, logic [15:0] row,
                                               logic [15:0] col,
                                               logic [VAL_W-1:0] v, logic last);
    result_beat_t r;
    r.result_kind = kind; r.row_index = row; r.col_index = col;
    r.value = v; r.is_last = last;
    return r;
  endfunction

  task automatic assemble_face(input face_beat_t f);
    logic [32:0] len;
    logic signed [VAL_W-1:0] diag, off, half;
    if (f.action == ACT_WRITE) begin
      if (f.node_a < NODES) load_shadow[f.node_a] = f.load_data;
      return;
    end
    if (f.action == ACT_READ) begin
      add_expected(make_result(RES_LOAD, f.node_a, '0,
        (f.node_a < NODES) ? load_shadow[f.node_a] : '0, 1'b1));
      return;
    end
    if (f.action != ACT_FACE) return;
    if (f.face_kind != KIND_NEUMANN && f.face_kind != KIND_ROBIN) return;
    if (f.node_a >= node_limit || f.node_a >= NODES) return;
    if (f.node_b >= node_limit || f.node_b >= NODES) return;
    len = edge_len(f.ax, f.ay, f.bx, f.by_coord);
    if (len == 0) return;
    if (f.face_kind == KIND_NEUMANN) begin
      half = scale_term(f.flux_coef, len, 2);
    end else begin
      diag = scale_term(f.robin_k, len, 3);
      off  = scale_term(f.robin_k, len, 6);
      add_expected(make_result(RES_TRIPLET, f.node_a, f.node_a, diag, 1'b0));
      add_expected(make_result(RES_TRIPLET, f.node_a, f.node_b, off, 1'b0));
      add_expected(make_result(RES_TRIPLET, f.node_b, f.node_a, off, 1'b0));
      add_expected(make_result(RES_TRIPLET, f.node_b, f.node_b, diag, 1'b1));
      half = scale_term(f.robin_g, len, 2);
    end
    load_shadow[f.node_a] = sat_sum48(load_shadow[f.node_a], half);
    load_shadow[f.node_b] = sat_sum48(load_shadow[f.node_b], half);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the beat until taken
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        assemble_face(pending_beats.pop_front());
        drv_wait = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) drv_wait = 0;
      end
      if (drv_wait > 0) begin
        drv_wait--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.action    <= pending_beats[0].action;
        in_ch.face_kind <= pending_beats[0].face_kind;
        in_ch.node_a    <= pending_beats[0].node_a;
        in_ch.node_b    <= pending_beats[0].node_b;
        in_ch.ax        <= pending_beats[0].ax;
        in_ch.ay        <= pending_beats[0].ay;
        in_ch.bx        <= pending_beats[0].bx;
        in_ch.by_coord  <= pending_beats[0].by_coord;
        in_ch.flux_coef <= pending_beats[0].flux_coef;
        in_ch.robin_k   <= pending_beats[0].robin_k;
        in_ch.robin_g   <= pending_beats[0].robin_g;
        in_ch.load_data <= pending_beats[0].load_data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    result_beat_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: kind %0d row %0d col %0d value %0d",
                     out_ch.result_kind, out_ch.row_index, out_ch.col_index,
                     out_ch.value);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.result_kind !== exp_r.result_kind ||
              out_ch.row_index !== exp_r.row_index ||
              out_ch.col_index !== exp_r.col_index ||
              out_ch.value !== exp_r.value || out_ch.is_last !== exp_r.is_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp k%0d r%0d c%0d v%0d l%0d, got k%0d r%0d c%0d v%0d l%0d",
                       exp_r.result_kind, exp_r.row_index, exp_r.col_index,
                       $signed(exp_r.value), exp_r.is_last, out_ch.result_kind,
                       out_ch.row_index, out_ch.col_index, out_ch.value, out_ch.is_last);
          end
        end
        rcv_wait = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) rcv_wait = 0;
      end
      // long hold-off lets the sender pile up against a full block
      if (long_hold > 0) begin
        long_hold--;
        out_ch.ready <= 1'b0;
      end else if (rcv_wait > 0) begin
        rcv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no beat on in_ch or out_ch
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  function automatic face_beat_t rand_face(int node_hi);
    face_beat_t f;
    int span;
    f.action    = ACT_FACE;
    f.face_kind = ($urandom_range(0, 9) < 6) ? KIND_ROBIN :
                  ($urandom_range(0, 3) != 0) ? KIND_NEUMANN : 2'($urandom_range(0, 1));
    f.node_a    = 16'($urandom_range(0, node_hi));
    f.node_b    = ($urandom_range(0, 7) == 0) ? f.node_a : 16'($urandom_range(0, node_hi));
    // mostly moderate coordinates, sometimes the full range
    span = ($urandom_range(0, 4) == 0) ? 0 : 22;
    if (span == 0) begin
      f.ax = $urandom; f.ay = $urandom; f.bx = $urandom; f.by_coord = $urandom;
    end else begin
      f.ax = $signed(32'($urandom)) >>> (32 - span);
      f.ay = $signed(32'($urandom)) >>> (32 - span);
      f.bx = $signed(32'($urandom)) >>> (32 - span);
      f.by_coord = $signed(32'($urandom)) >>> (32 - span);
    end
    f.flux_coef = ($urandom_range(0, 1)) ? $urandom : $signed(32'($urandom)) >>> 10;
    f.robin_k   = ($urandom_range(0, 1)) ? $urandom : $signed(32'($urandom)) >>> 10;
    f.robin_g   = ($urandom_range(0, 1)) ? $urandom : $signed(32'($urandom)) >>> 10;
    f.load_data = 48'({$urandom, $urandom});
    return f;
  endfunction

  function automatic face_beat_t mem_beat(logic [1:0] act, logic [15:0] idx,
                                          logic [VAL_W-1:0] data);
    face_beat_t f;
    f = rand_face(NODES - 1);
    f.action = act; f.node_a = idx; f.load_data = data;
    return f;
  endfunction

  function automatic face_beat_t fixed_face(logic [1:0] kind, logic [15:0] a,
                                            logic [15:0] b, logic [31:0] x0,
                                            logic [31:0] y0, logic [31:0] x1,
                                            logic [31:0] y1, logic [31:0] c);
    face_beat_t f;
    f = rand_face(NODES - 1);
    f.face_kind = kind; f.node_a = a; f.node_b = b;
    f.ax = x0; f.ay = y0; f.bx = x1; f.by_coord = y1;
    f.flux_coef = c; f.robin_k = c; f.robin_g = ~c;
    return f;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    // a trailing neumann face yields nothing but may still be working
    repeat (200) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [NCNT_W-1:0] n);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    node_limit = n;
  endtask

  initial begin
    face_beat_t f;
    int node_hi;
    in_ch.valid = 0; in_ch.action = '0; in_ch.face_kind = '0;
    in_ch.node_a = '0; in_ch.node_b = '0; in_ch.ax = '0; in_ch.ay = '0;
    in_ch.bx = '0; in_ch.by_coord = '0; in_ch.flux_coef = '0; in_ch.robin_k = '0;
    in_ch.robin_g = '0; in_ch.load_data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.node_count = '0;
    for (int i = 0; i < NODES; i++) load_shadow[i] = '0;
    node_limit = NCNT_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: memory access extremes, every kind, skips, saturation
    queue_beat(mem_beat(ACT_READ, 16'd0, '0));
    queue_beat(mem_beat(ACT_WRITE, 16'd4095, 48'h7FFF_FFFF_FFFF));
    queue_beat(mem_beat(ACT_WRITE, 16'd0, 48'h8000_0000_0000));
    queue_beat(mem_beat(ACT_WRITE, 16'hFFFF, 48'h1234));
    queue_beat(mem_beat(ACT_READ, 16'hFFFF, '0));
    queue_beat(mem_beat(2'd3, 16'd5, '0));
    // robin faces between saturated entries push the node-0 load sum past the negative rail
    queue_beat(fixed_face(KIND_ROBIN, 16'd4095, 16'd0, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_beat(fixed_face(KIND_ROBIN, 16'd0, 16'd4095, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    queue_beat(mem_beat(ACT_READ, 16'd4095, '0));
    queue_beat(mem_beat(ACT_READ, 16'd0, '0));
    queue_beat(fixed_face(KIND_NEUMANN, 16'd7, 16'd7, 32'h0, 32'h0,
      32'h0003_0000, 32'h0004_0000, 32'h0001_8000));
    queue_beat(fixed_face(KIND_ROBIN, 16'd7, 16'd7, 32'h0, 32'h0,
      32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000));
    queue_beat(fixed_face(KIND_ROBIN, 16'd3, 16'd4, 32'h10, 32'h20,
      32'h10, 32'h20, 32'h0001_0000));
    queue_beat(fixed_face(KIND_NONE, 16'd3, 16'd4, 0, 0, 32'h1_0000, 0, 1));
    queue_beat(fixed_face(KIND_DIRICHLET, 16'd3, 16'd4, 0, 0, 32'h1_0000, 0, 1));
    queue_beat(fixed_face(KIND_ROBIN, 16'd4096, 16'd4, 0, 0, 32'h1_0000, 0, 1));
    queue_beat(fixed_face(KIND_ROBIN, 16'd3, 16'hFFFF, 0, 0, 32'h1_0000, 0, 1));
    queue_beat(fixed_face(KIND_ROBIN, 16'd9, 16'd10, 0, 0, 32'h0, 32'h1, 32'h5));
    queue_beat(mem_beat(ACT_READ, 16'd7, '0));
    queue_beat(mem_beat(ACT_READ, 16'd9, '0));
    wait_drained();

    // random phases under several node counts, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_node_count(13'd16);
        1: write_node_count(13'd0);
        2: write_node_count(13'h1FFF);
        3: write_node_count(13'($urandom_range(1, 4096)));
        default: write_node_count(13'd4096);
      endcase
      node_hi = (phase == 1) ? 20 : (node_limit > 4096 ? 4200 : int'(node_limit) + 3);
      if (phase == 2) begin
        // receiver stays off for a long stretch while faces keep coming
        long_hold = 3000;
      end
      for (int i = 0; i < 96; i++) begin
        case ($urandom_range(0, 9))
          0: f = mem_beat(ACT_WRITE, ($urandom_range(0, 15) == 0) ?
                 16'($urandom) : 16'($urandom_range(0, node_hi)),
                 48'({$urandom, $urandom}));
          1, 2: f = mem_beat(ACT_READ, ($urandom_range(0, 15) == 0) ?
                 16'($urandom) : 16'($urandom_range(0, node_hi)), '0);
          3: begin
            f = rand_face(node_hi);
            f.node_a = $urandom; f.node_b = $urandom;
            f.action = 2'($urandom_range(0, 3));
          end
          default: f = rand_face(node_hi);
        endcase
        queue_beat(f);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
